// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define VDH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next one.
`define VDH_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/vdh_pkg.sv -----
`default_nettype none

package vdh_pkg;

  // Input transaction payload
  typedef struct packed {
    logic [1:0] command;
    logic [8:0] row;
    logic [7:0] disparity;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [7:0] count;
    logic       counted;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_ACCUMULATE = 2'd0,
    CMD_READ       = 2'd1,
    CMD_CLEAR      = 2'd2
  } cmd_t;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,  // no store access, result is zero
    JOB_READ  = 2'd1,  // return the bin as is
    JOB_ACC   = 2'd2,  // saturating increment of the bin
    JOB_CLEAR = 2'd3   // sweep the whole store
  } job_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  localparam logic       CFG_LOWER_LIMIT = 1'b0;
  localparam logic       CFG_UPPER_LIMIT = 1'b1;
  localparam int         CFG_DATA_W      = 9;
  localparam logic [7:0] LOWER_RESET     = 8'd0;
  localparam logic [8:0] UPPER_RESET     = 9'd225;
  localparam logic [7:0] COUNT_MAX       = 8'd255;
  localparam logic [7:0] COUNT_ZERO      = 8'd0;

endpackage

`default_nettype wire

// ----- src/v_disparity_histogram_unit.sv -----
// Channel  Handshake            Payload               Direction
// cfg      cfg_we               cfg_index, cfg_data   in
// in       in_valid / in_stall  in_data (in_item_t)   in
// out      out_valid/out_stall  out_data (out_item_t) out
//
// In the back end, accumulate and read transactions first read the single-port
// histogram store (registered read) on pop, then update and write in ST_READ.
// Unused commands and out-of-range bins load a zero result directly on pop.
// Clear loads a zero result on pop, then sweeps the store with in_stall high.
// After rst all ROWS*BINS bins (131072 at defaults) are swept with in_stall
// high; configuration writes are taken throughout.
// A 2-deep queue lets the front take transactions while out is stalled.
`default_nettype none

module v_disparity_histogram_unit #(
  parameter int ROWS = 512,
  parameter int BINS = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [vdh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire vdh_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output vdh_pkg::out_item_t                  out_data
);
  import vdh_pkg::*;

  // one 8-bit counter per (row, disparity) pair, flat address row*BINS + disparity
  localparam int DEPTH = ROWS * BINS;
  localparam int AW    = $clog2(DEPTH);

  logic          push;
  job_kind_t     push_kind;
  logic [AW-1:0] push_addr;
  logic          pop;
  job_kind_t     head_kind;
  logic [AW-1:0] head_addr;
  q_flags_t      q_flags;
  logic          clearing;

  // front: limits, range and window checks, bin address
  vdh_front #(
    .ROWS (ROWS),
    .BINS (BINS),
    .AW   (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .clearing  (clearing),
    .q_flags   (q_flags),
    .push      (push),
    .push_kind (push_kind),
    .push_addr (push_addr)
  );

  // decouples the front from the store sequencer
  vdh_queue #(
    .AW (AW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_kind (push_kind),
    .push_addr (push_addr),
    .pop       (pop),
    .head_kind (head_kind),
    .head_addr (head_addr),
    .q_flags   (q_flags)
  );

  // back: store, read-modify-write, clear sweep, output register
  vdh_back #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_kind (head_kind),
    .head_addr (head_addr),
    .q_flags   (q_flags),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- src/vdh_front.sv -----
`default_nettype none

module vdh_front #(
  parameter int ROWS = 512,
  parameter int BINS = 256,
  parameter int AW   = 17
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [vdh_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire vdh_pkg::in_item_t                 in_data,
  input  wire logic                              clearing,
  input  wire vdh_pkg::q_flags_t                 q_flags,
  output logic                                   push,
  output vdh_pkg::job_kind_t                     push_kind,
  output logic [AW-1:0]                          push_addr
);
  import vdh_pkg::*;

  logic [7:0] lower_limit;
  logic [8:0] upper_limit;
  logic       in_range;
  logic       in_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit <= LOWER_RESET;
      upper_limit <= UPPER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER_LIMIT: lower_limit <= cfg_data[7:0];
        CFG_UPPER_LIMIT: upper_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // no new work while the store is being swept or the queue is full
  assign in_stall = q_flags.full || clearing;
  assign push     = in_valid && !in_stall;

  assign in_range  = (32'(in_data.row) < ROWS) && (32'(in_data.disparity) < BINS);
  assign in_window = (in_data.disparity > lower_limit) &&
                     ({1'b0, in_data.disparity} < upper_limit);
  assign push_addr = AW'(32'(in_data.row) * BINS + 32'(in_data.disparity));

  always_comb begin
    case (in_data.command)
      CMD_ACCUMULATE: push_kind = !in_range ? JOB_NONE : (in_window ? JOB_ACC : JOB_READ);
      CMD_READ:       push_kind = in_range ? JOB_READ : JOB_NONE;
      CMD_CLEAR:      push_kind = JOB_CLEAR;
      default:        push_kind = JOB_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/vdh_queue.sv -----
`default_nettype none
`include "assert_macros.svh"

module vdh_queue #(
  parameter int AW = 17
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire vdh_pkg::job_kind_t push_kind,
  input  wire logic [AW-1:0]      push_addr,
  input  wire logic               pop,
  output vdh_pkg::job_kind_t      head_kind,
  output logic [AW-1:0]           head_addr,
  output vdh_pkg::q_flags_t       q_flags
);
  import vdh_pkg::*;

  localparam int QD = 2;

  job_kind_t     kind_q [QD];
  logic [AW-1:0] addr_q [QD];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr] <= push_kind;
      addr_q[wr_ptr] <= push_addr;
    end
  end

  assign head_kind     = kind_q[rd_ptr];
  assign head_addr     = addr_q[rd_ptr];
  assign q_flags.full  = (fill == 2'(QD));
  assign q_flags.empty = (fill == 2'd0);

  `VDH_ASSERT(a_no_overflow, !(push && q_flags.full), "push into full queue")
  `VDH_ASSERT(a_no_underflow, !(pop && q_flags.empty), "pop from empty queue")

endmodule

`default_nettype wire

// ----- src/vdh_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module vdh_back #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire vdh_pkg::job_kind_t head_kind,
  input  wire logic [AW-1:0]      head_addr,
  input  wire vdh_pkg::q_flags_t  q_flags,
  output logic                    pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output vdh_pkg::out_item_t      out_data
);
  import vdh_pkg::*;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;

  back_state_t   state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [AW-1:0] hold_addr;
  logic          hold_acc;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  logic          out_free;
  logic          load;
  out_item_t     load_data;
  logic          bump;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && !q_flags.empty && out_free;
  assign clearing = (state == ST_CLEAR);
  assign bump     = hold_acc && (rd_data != COUNT_MAX);

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    mem_we         = 1'b0;
    mem_waddr      = hold_addr;
    mem_wdata      = COUNT_ZERO;
    load           = 1'b0;
    load_data      = '{count: COUNT_ZERO, counted: 1'b0};
    case (state)
      ST_IDLE: begin
        if (pop) begin
          case (head_kind)
            JOB_READ, JOB_ACC: state_next = ST_READ;
            JOB_CLEAR: begin
              state_next    = ST_CLEAR;
              clr_addr_next = '0;
              load          = 1'b1;
            end
            default: load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        mem_we    = bump;
        mem_wdata = bump ? rd_data + 8'd1 : rd_data;
        load      = 1'b1;
        load_data = '{count: mem_wdata, counted: bump};
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= load_data;
    if (pop) begin
      hold_addr <= head_addr;
      hold_acc  <= (head_kind == JOB_ACC);
    end
  end

  // single-port store: registered read, one write per cycle
  always_ff @(posedge clk) begin
    if (pop) rd_data <= mem[head_addr];
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  `VDH_ASSERT(a_read_slot_free, !((state == ST_READ) && out_valid), "output busy on update")
  `VDH_ASSERT(a_counted_nonzero, !(out_valid && out_data.counted && (out_data.count == COUNT_ZERO)),
              "counted result with zero count")
  `VDH_ASSERT_NEXT(a_read_returns, (state == ST_READ), (out_valid && (state == ST_IDLE)),
                   "update did not produce a result")

endmodule

`default_nettype wire
